// ===== hdl/bdsi_pkg.sv =====
package bdsi_pkg;

  localparam int unsigned Depth      = 16;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CountWidth = $clog2(Depth + 1);

  // request codes
  localparam logic [1:0] ReqPush = 2'd0;
  localparam logic [1:0] ReqPop  = 2'd1;
  localparam logic [1:0] ReqPeek = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CfgCapacityLimit = 2'd0;
  localparam logic [1:0] CfgSortedMode    = 2'd1;

  typedef enum logic [1:0] {
    StDone  = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

  // command broadcast to every cell
  typedef struct packed {
    logic                  push_en;
    logic                  pop_front_en;
    logic                  sorted;
    logic                  at_front;
    logic [ValueWidth-1:0] value;
  } cell_cmd_t;

  // where a cell sits relative to the fill level
  typedef struct packed {
    logic occupied;
    logic is_tail;
    logic is_next;
  } cell_pos_t;

endpackage

// ===== hdl/bdsi_cell.sv =====
module bdsi_cell
  import bdsi_pkg::*;
(
  input  logic                  clk_i,
  input  cell_cmd_t             cmd_i,
  input  cell_pos_t             pos_i,
  input  logic [ValueWidth-1:0] left_val_i,
  input  logic                  left_done_i,
  input  logic [ValueWidth-1:0] right_val_i,
  input  logic [ValueWidth-1:0] rd_i,
  output logic [ValueWidth-1:0] val_o,
  output logic                  done_o,
  output logic [ValueWidth-1:0] rd_o
);

  logic [ValueWidth-1:0] val_q, val_d;
  logic                  want;
  logic                  here;

  // insertion point: first occupied cell that wants the value, or the first free cell
  always_comb begin
    if (cmd_i.sorted) begin
      want = pos_i.occupied && (cmd_i.value <= val_q);
    end else begin
      want = pos_i.occupied && cmd_i.at_front;
    end
    here = !left_done_i && (want || pos_i.is_next);
  end

  assign done_o = left_done_i || here;

  // next value: insert, shift right behind the insertion point, or shift left on front pop
  always_comb begin
    val_d = val_q;
    if (cmd_i.push_en) begin
      if (here) begin
        val_d = cmd_i.value;
      end else if (left_done_i) begin
        val_d = left_val_i;
      end
    end else if (cmd_i.pop_front_en) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

  // tail value travels along the read chain
  assign rd_o = rd_i | (pos_i.is_tail ? val_q : '0);

endmodule

// ===== hdl/bounded_deque_sorted_insert.sv =====
// Bounded double-ended queue built as a row of shift cells. An operation is
// accepted whenever start is high; busy stays low, so one push, pop or peek
// is taken every clock cycle. Its result appears on the result ports for one
// cycle, flagged by result_valid_o, in the cycle after the transfer: the
// whole cell row compares and shifts in that single cycle. The receiver
// cannot stall, so results must be captured when the strobe is seen. In
// sorted mode a push lands before the first stored value that is greater
// than or equal to it; otherwise at the front or back. Every result carries
// the entry count held before the operation. Configuration writes are always
// ready and are meant to be made while no operation is in flight.
module bounded_deque_sorted_insert
  import bdsi_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // command channel
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            req_type_i,
  input  logic                  at_front_i,
  input  logic [31:0]           push_value_i,
  // result channel
  output logic                  result_valid_o,
  output logic [1:0]            status_o,
  output logic [31:0]           read_value_o,
  output logic [4:0]            count_before_o,
  // configuration channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [31:0]           cfg_data_i
);

  logic [CountWidth-1:0] count_q, count_d;
  logic [4:0]            cap_limit_q;
  logic                  sorted_q;
  logic                  accept;
  logic [CountWidth-1:0] eff_limit;
  logic                  full;
  logic                  empty;
  cell_cmd_t             cmd;
  cell_pos_t             pos      [Depth];
  logic [ValueWidth-1:0] cell_val [Depth];
  logic                  cell_done[Depth];
  logic [ValueWidth-1:0] cell_rd  [Depth];
  logic [ValueWidth-1:0] rd_value;
  status_e               status;

  logic                  res_valid_q;
  logic [1:0]            res_status_q;
  logic [31:0]           res_value_q;
  logic [4:0]            res_count_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_limit_q <= '0;
      sorted_q    <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CfgCapacityLimit) begin
        cap_limit_q <= cfg_data_i[4:0];
      end else if (cfg_index_i == CfgSortedMode) begin
        sorted_q <= cfg_data_i[0];
      end
    end
  end

  // effective limit saturates at the physical depth; zero means depth
  always_comb begin
    if (cap_limit_q == '0 || 32'(cap_limit_q) > Depth) begin
      eff_limit = CountWidth'(Depth);
    end else begin
      eff_limit = CountWidth'(cap_limit_q);
    end
  end

  assign full  = count_q >= eff_limit;
  assign empty = count_q == '0;

  // broadcast command
  always_comb begin
    cmd.push_en      = accept && (req_type_i == ReqPush) && !full;
    cmd.pop_front_en = accept && (req_type_i == ReqPop) && !empty && at_front_i;
    cmd.sorted       = sorted_q;
    cmd.at_front     = at_front_i;
    cmd.value        = ValueWidth'(push_value_i);
  end

  // cell row
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic [ValueWidth-1:0] left_val;
    logic                  left_done;
    logic [ValueWidth-1:0] right_val;
    logic [ValueWidth-1:0] rd_in;

    assign pos[i].occupied = 32'(count_q) > i;
    assign pos[i].is_tail  = 32'(count_q) == i + 1;
    assign pos[i].is_next  = 32'(count_q) == i;

    if (i == 0) begin : g_first
      assign left_val  = '0;
      assign left_done = 1'b0;
      assign rd_in     = '0;
    end else begin : g_mid
      assign left_val  = cell_val[i-1];
      assign left_done = cell_done[i-1];
      assign rd_in     = cell_rd[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_notlast
      assign right_val = cell_val[i+1];
    end

    bdsi_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .pos_i      (pos[i]),
      .left_val_i (left_val),
      .left_done_i(left_done),
      .right_val_i(right_val),
      .rd_i       (rd_in),
      .val_o      (cell_val[i]),
      .done_o     (cell_done[i]),
      .rd_o       (cell_rd[i])
    );
  end

  assign rd_value = at_front_i ? cell_val[0] : cell_rd[Depth-1];

  // fill count and status
  always_comb begin
    count_d = count_q;
    status  = StDone;
    if (req_type_i == ReqPush) begin
      if (full) begin
        status = StFull;
      end else begin
        count_d = count_q + 1'b1;
      end
    end else if (req_type_i == ReqPop || req_type_i == ReqPeek) begin
      if (empty) begin
        status = StEmpty;
      end else if (req_type_i == ReqPop) begin
        count_d = count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_status_q <= status;
      res_count_q  <= 5'(count_q);
      if ((req_type_i == ReqPop || req_type_i == ReqPeek) && !empty) begin
        res_value_q <= 32'(rd_value);
      end else begin
        res_value_q <= '0;
      end
    end
  end

  assign result_valid_o = res_valid_q;
  assign status_o       = res_status_q;
  assign read_value_o   = res_value_q;
  assign count_before_o = res_count_q;

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni) 32'(count_q) <= Depth)
    else $error("entry count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_type_i == ReqPush && full |=> count_q == $past(count_q))
    else $error("refused push changed the count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_type_i == ReqPush && !full |=> count_q == $past(count_q) + 1'b1)
    else $error("accepted push did not grow the count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> 32'(count_before_o) == 32'($past(count_q)))
    else $error("reported count differs from count at transfer");

endmodule

// ===== verif/deque_checker.sv =====
`timescale 1ns / 1ps

// Watches the command, result and register channels of the deque, keeps its
// own copy of the queue contents and settings, and compares every result
// against the oldest prediction still outstanding.
module deque_checker
  import bdsi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  req_type_i,
  input  logic        at_front_i,
  input  logic [31:0] push_value_i,
  input  logic        result_valid_i,
  input  logic [1:0]  status_i,
  input  logic [31:0] read_value_i,
  input  logic [4:0]  count_before_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned results_o,
  output int unsigned full_seen_o,
  output int unsigned empty_seen_o
);

  typedef struct packed {
    status_e              status;
    logic [31:0]          value;
    logic [4:0]           count;
  } deque_result_t;

  // predicted queue contents, front at index 0
  logic [ValueWidth-1:0] store [Depth];
  int unsigned           held;
  logic [4:0]            cap_limit;
  logic                  sorted_mode;

  deque_result_t expected_results [$];
  int unsigned   errors;
  int unsigned   results;
  int unsigned   full_seen;
  int unsigned   empty_seen;

  assign fail_count_o = errors;
  assign results_o    = results;
  assign full_seen_o  = full_seen;
  assign empty_seen_o = empty_seen;

  task automatic report_error(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // applies one operation to the predicted queue and returns its result
  function automatic deque_result_t apply_request(input logic [1:0] req, input logic front,
                                                  input logic [31:0] value);
    deque_result_t res;
    int unsigned   limit;
    int unsigned   pos;
    int unsigned   idx;
    res.status = StDone;
    res.value  = '0;
    res.count  = 5'(held);
    limit = (cap_limit == 0 || cap_limit > Depth) ? Depth : cap_limit;
    case (req)
      ReqPush: begin
        if (held >= limit) begin
          res.status = StFull;
        end else begin
          pos = held;
          if (sorted_mode) begin
            // first stored value >= the new one
            for (idx = 0; idx < held; idx++)
              if (value <= store[idx] && pos == held) pos = idx;
          end else if (front) begin
            pos = 0;
          end
          for (idx = held; idx > pos; idx--) store[idx] = store[idx-1];
          store[pos] = value;
          held++;
        end
      end
      ReqPop, ReqPeek: begin
        if (held == 0) begin
          res.status = StEmpty;
        end else begin
          pos = front ? 0 : held - 1;
          res.value = store[pos];
          if (req == ReqPop) begin
            for (idx = pos; idx + 1 < held; idx++) store[idx] = store[idx+1];
            held--;
          end
        end
      end
      default: ;  // unused code: no change
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    deque_result_t want;
    if (!rst_ni) begin
      held        = 0;
      cap_limit   = '0;
      sorted_mode = 1'b0;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      // command transfer: predict its result
      if (start_i && !busy_i) begin
        want = apply_request(req_type_i, at_front_i, push_value_i);
        expected_results.push_back(want);
      end

      // register write
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgCapacityLimit: cap_limit = cfg_data_i[4:0];
          CfgSortedMode:    sorted_mode = cfg_data_i[0];
          default: ;
        endcase
      end

      // result transfer: compare with the oldest prediction
      if (result_valid_i) begin
        if (expected_results.size() == 0) begin
          report_error("result with no operation outstanding");
        end else begin
          want = expected_results.pop_front();
          results++;
          if (want.status == StFull) full_seen++;
          if (want.status == StEmpty) empty_seen++;
          if (status_i !== want.status)
            report_error($sformatf("result %0d: status %0d, expected %0d",
                                   results, status_i, want.status));
          if (read_value_i !== want.value)
            report_error($sformatf("result %0d: read_value %08h, expected %08h",
                                   results, read_value_i, want.value));
          if (count_before_i !== want.count)
            report_error($sformatf("result %0d: count_before %0d, expected %0d",
                                   results, count_before_i, want.count));
        end
      end

      pending_o <= expected_results.size();
    end
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import bdsi_pkg::*;

  localparam logic [1:0]  ReqUnused  = 2'd3;
  localparam int unsigned PhaseItems = 135;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        start_i      = 1'b0;
  logic [1:0]  req_type_i   = ReqPush;
  logic        at_front_i   = 1'b0;
  logic [31:0] push_value_i = '0;
  logic        cfg_valid_i  = 1'b0;
  logic [1:0]  cfg_index_i  = CfgCapacityLimit;
  logic [31:0] cfg_data_i   = '0;

  logic        busy_o;
  logic        result_valid_o;
  logic [1:0]  status_o;
  logic [31:0] read_value_o;
  logic [4:0]  count_before_o;
  logic        cfg_ready_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results_seen;
  int unsigned full_seen;
  int unsigned empty_seen;

  int unsigned op_tally [4] = '{0, 0, 0, 0};
  int unsigned settings_used = 0;
  int unsigned push_weight = 45;
  bit          idle_on = 1'b0;

  // fixed register settings, one per phase; includes limits above depth
  int unsigned phase_limit  [8] = '{0, 16, 1, 31, 17, 4, 0, 9};
  bit          phase_sorted [8] = '{1, 0, 0, 1, 0, 1, 0, 1};

  bounded_deque_sorted_insert uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start_i),
    .busy           (busy_o),
    .req_type_i     (req_type_i),
    .at_front_i     (at_front_i),
    .push_value_i   (push_value_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .read_value_o   (read_value_o),
    .count_before_o (count_before_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  deque_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .req_type_i     (req_type_i),
    .at_front_i     (at_front_i),
    .push_value_i   (push_value_i),
    .result_valid_i (result_valid_o),
    .status_i       (status_o),
    .read_value_i   (read_value_o),
    .count_before_i (count_before_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_o      (results_seen),
    .full_seen_o    (full_seen),
    .empty_seen_o   (empty_seen)
  );

  // 50 MHz clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // one command transfer, after an optional gap and an optional drain
  task automatic issue_op(input logic [1:0] req, input logic front, input logic [31:0] value,
                          input int unsigned gap, input bit drain);
    if (gap != 0 || drain) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      if (drain) begin
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
    end
    start_i      <= 1'b1;
    req_type_i   <= req;
    at_front_i   <= front;
    push_value_i <= value;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    op_tally[req]++;
  endtask

  // stop issuing and let every outstanding result come back
  task automatic quiesce();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] index, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_setting(input int unsigned limit, input bit sorted);
    quiesce();
    write_register(CfgCapacityLimit, 32'(limit));
    write_register(CfgSortedMode, 32'(sorted));
    settings_used++;
  endtask

  // op mix follows push_weight so the queue drifts toward full or empty
  function automatic logic [1:0] pick_request();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return ReqUnused;
    if (roll < 4 + push_weight) return ReqPush;
    if ($urandom_range(0, 4) < 3) return ReqPop;
    return ReqPeek;
  endfunction

  // small values make ties likely in sorted mode
  function automatic logic [31:0] draw_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return 32'($urandom_range(0, 7));
      5:       return 32'(1) << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned ph;
    int unsigned n;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty queue, both ends, full at a small limit
    apply_setting(2, 1'b0);
    issue_op(ReqPop,    1'b1, '0, 0, 1'b0);
    issue_op(ReqPeek,   1'b0, '0, 0, 1'b0);
    issue_op(ReqPop,    1'b0, '0, 0, 1'b0);
    issue_op(ReqPeek,   1'b1, '0, 0, 1'b0);
    issue_op(ReqUnused, 1'b1, 32'hDEAD_BEEF, 0, 1'b0);
    issue_op(ReqPush,   1'b1, 32'h0000_0000, 0, 1'b0);
    issue_op(ReqPush,   1'b0, 32'hFFFF_FFFF, 0, 1'b0);
    issue_op(ReqPush,   1'b1, 32'h1234_5678, 0, 1'b0);
    issue_op(ReqPeek,   1'b1, '0, 0, 1'b0);
    issue_op(ReqPeek,   1'b0, '0, 0, 1'b0);
    issue_op(ReqUnused, 1'b0, '0, 0, 1'b0);
    issue_op(ReqPop,    1'b0, '0, 0, 1'b0);
    issue_op(ReqPop,    1'b1, '0, 0, 1'b0);
    issue_op(ReqPop,    1'b1, '0, 0, 1'b0);

    // directed: sorted insertion, ties, front flag ignored
    apply_setting(0, 1'b1);
    issue_op(ReqPush, 1'b1, 32'd5, 0, 1'b0);
    issue_op(ReqPush, 1'b1, 32'hFFFF_FFFF, 0, 1'b0);
    issue_op(ReqPush, 1'b0, 32'd0, 0, 1'b0);
    issue_op(ReqPush, 1'b0, 32'd5, 0, 1'b0);
    issue_op(ReqPush, 1'b1, 32'hA5A5_A5A5, 0, 1'b0);
    issue_op(ReqPeek, 1'b1, '0, 0, 1'b0);
    issue_op(ReqPeek, 1'b0, '0, 0, 1'b0);
    issue_op(ReqPop,  1'b1, '0, 0, 1'b0);
    issue_op(ReqPop,  1'b0, '0, 0, 1'b0);
    issue_op(ReqPop,  1'b1, '0, 0, 1'b0);

    // random phases, each under its own register setting
    for (ph = 0; ph < 8; ph++) begin
      apply_setting(phase_limit[ph], phase_sorted[ph]);
      for (n = 0; n < PhaseItems; n++) begin
        if (n % 30 == 0) begin
          idle_on = $urandom_range(0, 2) != 0;
          case ($urandom_range(0, 2))
            0:       push_weight = 25;
            1:       push_weight = 45;
            default: push_weight = 75;
          endcase
        end
        issue_op(pick_request(), 1'($urandom_range(0, 1)), draw_value(),
                 idle_on ? $urandom_range(0, 14) : 0,
                 ($urandom_range(0, 99) == 0) || n == PhaseItems / 2);
      end
    end

    quiesce();
    repeat (4) @(posedge clk_i);

    $display("Ran %0d operations (push %0d, pop %0d, peek %0d, unused code %0d) under %0d settings.",
             op_tally[0] + op_tally[1] + op_tally[2] + op_tally[3],
             op_tally[0], op_tally[1], op_tally[2], op_tally[3], settings_used);
    $display("Checked %0d results: %0d pushes refused as full, %0d pops or peeks on empty.",
             results_seen, full_seen, empty_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
